// ===== hdl/jps_pkg.sv =====
// ----------------------------------------------------------------------------
// jps_pkg
// Shared types, codes and constants of the joint angle servo.
// ----------------------------------------------------------------------------
package jps_pkg;

	// Angles are in hundredths of a degree
	localparam int FULL_TURN = 36000;
	localparam int HALF_TURN = 18000;

	// Speed = floor(|error| * kp / SPEED_SCALE), division by reciprocal
	localparam int SPEED_SCALE = 10000;
	localparam int RECIP_SHIFT = 35;
	localparam logic [21:0] RECIP_MULT = 22'd3435974;

	// Configuration register map
	localparam int REG_ADDR_W = 5;
	localparam logic [2:0] REG_KP_GAIN       = 3'd0;
	localparam logic [2:0] REG_DEADBAND      = 3'd1;
	localparam logic [2:0] REG_SPEED_FLOOR   = 3'd2;
	localparam logic [2:0] REG_SPEED_CEILING = 3'd3;
	localparam logic [2:0] REG_LOOP_ENABLED  = 3'd4;

	typedef enum logic [2:0] {
		CMD_SAMPLE     = 3'd0,
		CMD_SET_TARGET = 3'd1,
		CMD_SET_LIMITS = 3'd2,
		CMD_SET_OFFSET = 3'd3,
		CMD_SET_SIGN   = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LIMITED  = 2'd1,
		ST_DISABLED = 2'd2,
		ST_REJECTED = 2'd3
	} status_e;

	typedef struct packed {
		logic [13:0] kp_gain;
		logic [10:0] deadband;
		logic [6:0]  speed_floor;
		logic [6:0]  speed_ceiling;
		logic        loop_enabled;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		kp_gain:       14'd500,
		deadband:      11'd80,
		speed_floor:   7'd18,
		speed_ceiling: 7'd70,
		loop_enabled:  1'b0
	};

	// One row of the joint memory
	typedef struct packed {
		logic signed [15:0] target;
		logic signed [15:0] lim_min;
		logic signed [15:0] lim_max;
		logic signed [16:0] offset;
		logic               rev;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	localparam entry_t RESET_ENTRY = '{
		target:  16'sd0,
		lim_min: -16'sd18000,
		lim_max: 16'sd17999,
		offset:  17'sd0,
		rev:     1'b0
	};

	// Item bookkeeping that rides along the arithmetic stages
	typedef struct packed {
		logic [3:0] joint;
		logic       sample;
		logic       enabled;
		logic       rev;
		status_e    status;
	} meta_t;

	// Hand-off from the memory stage to the arithmetic stages
	typedef struct packed {
		meta_t              meta;
		logic signed [15:0] tgt;
		logic signed [17:0] diff;
	} stage_t;

endpackage

// ===== hdl/jps_req_if.sv =====
// ----------------------------------------------------------------------------
// jps_req_if
// Command channel of the joint angle servo.
// ----------------------------------------------------------------------------
interface jps_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic [3:0]         joint;
	logic [15:0]        encoder_angle;
	logic signed [15:0] target_angle;
	logic signed [15:0] limit_low;
	logic signed [15:0] limit_high;
	logic signed [16:0] zero_offset;
	logic               reverse_sign;

	modport source (
		output valid, cmd, joint, encoder_angle, target_angle, limit_low, limit_high,
		       zero_offset, reverse_sign,
		input  ready
	);
	modport sink (
		input  valid, cmd, joint, encoder_angle, target_angle, limit_low, limit_high,
		       zero_offset, reverse_sign,
		output ready
	);
endinterface

// ===== hdl/jps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// jps_rsp_if
// Result channel of the joint angle servo.
// ----------------------------------------------------------------------------
interface jps_rsp_if;
	logic               valid;
	logic               ready;
	logic [3:0]         out_joint;
	logic [6:0]         drive_pct;
	logic               forward;
	logic signed [15:0] current_angle;
	logic signed [15:0] angle_error;
	logic               reached;
	logic [1:0]         status;

	modport source (
		output valid, out_joint, drive_pct, forward, current_angle, angle_error,
		       reached, status,
		input  ready
	);
	modport sink (
		input  valid, out_joint, drive_pct, forward, current_angle, angle_error,
		       reached, status,
		output ready
	);
endinterface

// ===== hdl/jps_ram.sv =====
// ----------------------------------------------------------------------------
// jps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hdl/jps_state.sv =====
// ----------------------------------------------------------------------------
// jps_state
// Joint memory stage: read on transfer, modify in stage 1, write back.
// ----------------------------------------------------------------------------
module jps_state import jps_pkg::*; #(
	parameter int NUM_JOINTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	jps_req_if.sink     req,
	input  logic        loop_enabled,
	input  logic        take,
	output logic        valid_s1,
	output stage_t      stage_s1
);
	localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

	logic                  ready_s1;
	logic                  accept;
	logic                  joint_ok;
	logic                  ok_s1;
	logic                  rvld_s1;
	cmd_e                  cmd_s1;
	logic [3:0]            joint_s1;
	logic [AW-1:0]         addr_s1;
	logic [15:0]           enc_s1;
	logic signed [15:0]    req_tgt_s1;
	logic signed [15:0]    lo_s1;
	logic signed [15:0]    hi_s1;
	logic signed [16:0]    off_s1;
	logic                  rev_s1;
	logic                  en_s1;
	logic [NUM_JOINTS-1:0] vld_q;
	logic                  fw_en_q;
	logic [AW-1:0]         fw_addr_q;
	entry_t                fw_data_q;
	logic [ENTRY_W-1:0]    ram_rdata;
	entry_t                ent;
	entry_t                nxt;
	logic                  wr_need;
	logic                  wr_en;
	logic signed [15:0]    lim;
	logic signed [15:0]    tgt;
	status_e               status;
	logic                  sample;

	function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
	                                                input logic signed [15:0] lo,
	                                                input logic signed [15:0] hi);
		logic signed [15:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	assign ready_s1  = !valid_s1 || take;
	assign req.ready = ready_s1;
	assign accept    = req.valid && ready_s1;
	assign joint_ok  = ({1'b0, req.joint} < 5'(NUM_JOINTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd_e'(req.cmd);
			joint_s1   <= req.joint;
			addr_s1    <= req.joint[AW-1:0];
			ok_s1      <= joint_ok;
			rvld_s1    <= joint_ok ? vld_q[req.joint[AW-1:0]] : 1'b0;
			enc_s1     <= req.encoder_angle;
			req_tgt_s1 <= req.target_angle;
			lo_s1      <= req.limit_low;
			hi_s1      <= req.limit_high;
			off_s1     <= req.zero_offset;
			rev_s1     <= req.reverse_sign;
			en_s1      <= loop_enabled;
		end
	end

	jps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_JOINTS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (req.joint[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Previous write may land on the same edge as this read: forward it
	always_comb begin
		if (fw_en_q && (fw_addr_q == addr_s1)) begin
			ent = fw_data_q;
		end else if (rvld_s1) begin
			ent = entry_t'(ram_rdata);
		end else begin
			ent = RESET_ENTRY;
		end
	end

	always_comb begin
		nxt     = ent;
		wr_need = 1'b0;
		status  = ST_OK;
		sample  = 1'b0;
		tgt     = ent.target;
		lim     = clamp16(req_tgt_s1, ent.lim_min, ent.lim_max);
		if (!ok_s1) begin
			status = ST_REJECTED;
		end else begin
			case (cmd_s1)
				CMD_SET_TARGET: begin
					nxt.target = lim;
					wr_need    = 1'b1;
					status     = (lim != req_tgt_s1) ? ST_LIMITED : ST_OK;
				end
				CMD_SET_LIMITS: begin
					if (hi_s1 <= lo_s1) begin
						status = ST_REJECTED;
					end else begin
						nxt.lim_min = lo_s1;
						nxt.lim_max = hi_s1;
						wr_need     = 1'b1;
					end
				end
				CMD_SET_OFFSET: begin
					nxt.offset = off_s1;
					wr_need    = 1'b1;
				end
				CMD_SET_SIGN: begin
					nxt.rev = rev_s1;
					wr_need = 1'b1;
				end
				CMD_SAMPLE: begin
					sample = 1'b1;
					if (en_s1) begin
						tgt        = clamp16(ent.target, ent.lim_min, ent.lim_max);
						nxt.target = tgt;
						wr_need    = 1'b1;
					end else begin
						status = ST_DISABLED;
					end
				end
				default: begin
					status = ST_REJECTED;
				end
			endcase
		end
	end

	assign wr_en = valid_s1 && take && wr_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fw_en_q <= 1'b0;
		end else if (valid_s1 && take) begin
			fw_en_q <= wr_need;
			if (wr_need) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && take) begin
			fw_addr_q <= addr_s1;
			fw_data_q <= nxt;
		end
	end

	always_comb begin
		stage_s1.meta.joint   = joint_s1;
		stage_s1.meta.sample  = sample;
		stage_s1.meta.enabled = en_s1;
		stage_s1.meta.rev     = ent.rev;
		stage_s1.meta.status  = status;
		stage_s1.tgt          = tgt;
		stage_s1.diff         = $signed({2'b00, enc_s1}) - $signed({ent.offset[16], ent.offset});
	end
endmodule

// ===== hdl/jps_calc.sv =====
// ----------------------------------------------------------------------------
// jps_calc
// Arithmetic stages: angle wrap, error, gain, speed limits, result register.
// ----------------------------------------------------------------------------
module jps_calc import jps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     valid_s1,
	input  stage_t   stage_s1,
	output logic     take,
	jps_rsp_if.source rsp
);
	logic valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic r2, r3, r4, r5, r6;

	meta_t              meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [15:0] tgt_s2;
	logic signed [15:0] cur_s2, cur_s3, cur_s4, cur_s5;
	logic signed [15:0] err_s3, err_s4, err_s5;
	logic [14:0]        mag_s3;
	logic               reached_s4, reached_s5;
	logic [28:0]        prod_s4;
	logic               lo_hit_s5, hi_hit_s5;
	logic [42:0]        qprod_s5;

	logic signed [17:0] err_diff;
	logic signed [15:0] err_w;
	logic signed [15:0] err_neg;
	logic [20:0]        floor_lim;
	logic [20:0]        ceil_lim;
	logic [6:0]         quot;
	logic               active;

	// Reduce modulo a full turn into [-HALF_TURN, HALF_TURN); exact for
	// inputs in [-2 turns, 4 turns)
	function automatic logic signed [15:0] wrap_turn(input logic signed [17:0] d);
		logic signed [18:0] dx;
		logic signed [18:0] c;
		logic signed [15:0] r;
		dx = {d[17], d};
		r  = '0;
		for (int m = -2; m <= 4; m++) begin
			c = dx - 19'(m * FULL_TURN);
			if ((c >= 19'(-HALF_TURN)) && (c < 19'(HALF_TURN))) begin
				r = c[15:0];
			end
		end
		return r;
	endfunction

	assign r6   = !valid_s6 || rsp.ready;
	assign r5   = !valid_s5 || r6;
	assign r4   = !valid_s4 || r5;
	assign r3   = !valid_s3 || r4;
	assign r2   = !valid_s2 || r3;
	assign take = r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (r2) valid_s2 <= valid_s1;
			if (r3) valid_s3 <= valid_s2;
			if (r4) valid_s4 <= valid_s3;
			if (r5) valid_s5 <= valid_s4;
			if (r6) valid_s6 <= valid_s5;
		end
	end

	assign err_diff  = $signed({{2{tgt_s2[15]}}, tgt_s2}) - $signed({{2{cur_s2[15]}}, cur_s2});
	assign err_w     = wrap_turn(err_diff);
	assign err_neg   = -err_w;
	assign floor_lim = 21'(cfg.speed_floor) * 21'(SPEED_SCALE);
	assign ceil_lim  = (21'(cfg.speed_ceiling) + 21'd1) * 21'(SPEED_SCALE);
	assign quot      = qprod_s5[RECIP_SHIFT +: 7];
	assign active    = meta_s5.sample && meta_s5.enabled && !reached_s5;

	always_ff @(posedge clk) begin
		// wrap the corrected encoder angle
		if (r2) begin
			meta_s2 <= stage_s1.meta;
			tgt_s2  <= stage_s1.tgt;
			cur_s2  <= wrap_turn(stage_s1.diff);
		end
		// wrapped error and its magnitude
		if (r3) begin
			meta_s3 <= meta_s2;
			cur_s3  <= cur_s2;
			err_s3  <= err_w;
			mag_s3  <= err_w[15] ? err_neg[14:0] : err_w[14:0];
		end
		// deadband test and gain product
		if (r4) begin
			meta_s4    <= meta_s3;
			cur_s4     <= cur_s3;
			err_s4     <= err_s3;
			reached_s4 <= (mag_s3 <= 15'(cfg.deadband));
			prod_s4    <= 29'(mag_s3) * 29'(cfg.kp_gain);
		end
		// limit tests on the unscaled product, reciprocal multiply
		if (r5) begin
			meta_s5    <= meta_s4;
			cur_s5     <= cur_s4;
			err_s5     <= err_s4;
			reached_s5 <= reached_s4;
			lo_hit_s5  <= (prod_s4 < 29'(floor_lim));
			hi_hit_s5  <= (prod_s4 >= 29'(ceil_lim));
			qprod_s5   <= 43'(prod_s4[20:0]) * 43'(RECIP_MULT);
		end
		// result register
		if (r6) begin
			rsp.out_joint     <= meta_s5.joint;
			rsp.status        <= meta_s5.status;
			rsp.current_angle <= meta_s5.sample ? cur_s5 : 16'sd0;
			rsp.angle_error   <= meta_s5.sample ? err_s5 : 16'sd0;
			rsp.reached       <= meta_s5.sample && reached_s5;
			if (!active) begin
				rsp.drive_pct <= '0;
				rsp.forward   <= 1'b0;
			end else begin
				if (lo_hit_s5) begin
					rsp.drive_pct <= cfg.speed_floor;
				end else if (hi_hit_s5) begin
					rsp.drive_pct <= cfg.speed_ceiling;
				end else begin
					rsp.drive_pct <= quot;
				end
				rsp.forward <= (!err_s5[15] && (err_s5 != 16'sd0)) ^ meta_s5.rev;
			end
		end
	end

	assign rsp.valid = valid_s6;
endmodule

// ===== hdl/joint_angle_p_servo.sv =====
// ----------------------------------------------------------------------------
// joint_angle_p_servo
// Proportional joint position controller with deadband, per-joint state in
// a one-row-per-joint memory.
// ----------------------------------------------------------------------------
//
//   Channel   Kind            Direction   Moves
//   req       valid/ready     in          one command (sample or table update)
//   rsp       valid/ready     out         one result per command
//   APB       psel/penable    in/out      gain, deadband, speed limits, enable
//
// Rate: one transfer per cycle sustained while rsp takes results; a result
// passes every stage register in turn. The rate is set by the
// read-modify-write of the joint memory in stage 1; a write that lands on the
// same edge as the next read is forwarded from a holding register, so
// back-to-back commands to one joint need no interlock.
// Reset: control state, configuration and per-joint valid bits clear at
// once; a joint never written reads its reset row. No clearing pass.
// Stalls: each stage holds while the one after it is full and stalled, so
// bubbles close up, and req is taken while rsp waits until every stage is full.
// ----------------------------------------------------------------------------
module joint_angle_p_servo import jps_pkg::*; #(
	parameter int NUM_JOINTS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	jps_req_if.sink               req,
	jps_rsp_if.source             rsp
);
	cfg_t   cfg_q;
	logic   valid_s1;
	stage_t stage_s1;
	logic   take;

	// Register file: written in the access phase, zero wait states
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[REG_ADDR_W-1:2])
				REG_KP_GAIN:       cfg_q.kp_gain       <= pwdata[13:0];
				REG_DEADBAND:      cfg_q.deadband      <= pwdata[10:0];
				REG_SPEED_FLOOR:   cfg_q.speed_floor   <= pwdata[6:0];
				REG_SPEED_CEILING: cfg_q.speed_ceiling <= pwdata[6:0];
				REG_LOOP_ENABLED:  cfg_q.loop_enabled  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back the stored value, zero beyond the map
	always_comb begin
		case (paddr[REG_ADDR_W-1:2])
			REG_KP_GAIN:       prdata = 32'(cfg_q.kp_gain);
			REG_DEADBAND:      prdata = 32'(cfg_q.deadband);
			REG_SPEED_FLOOR:   prdata = 32'(cfg_q.speed_floor);
			REG_SPEED_CEILING: prdata = 32'(cfg_q.speed_ceiling);
			REG_LOOP_ENABLED:  prdata = 32'(cfg_q.loop_enabled);
			default:           prdata = '0;
		endcase
	end

	// Stage 1: joint memory read-modify-write, command decode
	jps_state #(
		.NUM_JOINTS (NUM_JOINTS)
	) u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.loop_enabled (cfg_q.loop_enabled),
		.take         (take),
		.valid_s1     (valid_s1),
		.stage_s1     (stage_s1)
	);

	// Stages 2..6: wrap, error, gain, speed limits, result register
	jps_calc u_calc (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.take     (take),
		.rsp      (rsp)
	);
endmodule
